/* sv/msort_pkg.sv */
package msort_pkg;

  localparam int unsigned MsMaxItems = 64;
  localparam int unsigned MsDataWidth = 32;

  localparam int unsigned MsStateWidth = 3;
  localparam logic [MsStateWidth-1:0] StLoad  = 3'd0;
  localparam logic [MsStateWidth-1:0] StSetup = 3'd1;
  localparam logic [MsStateWidth-1:0] StMerge = 3'd2;
  localparam logic [MsStateWidth-1:0] StRead  = 3'd3;
  localparam logic [MsStateWidth-1:0] StEmit  = 3'd4;

endpackage

/* sv/merge_sorter_top.sv */
// Channel | Handshake              | Payload
// --------+------------------------+-------------------------------------------
// input   | in_valid_i / in_stall_o | sample_value_i (s32), final_item_i
// output  | out_valid_o / out_stall_i | sorted_value_o (s32), run_end_o, overflowed_o
//
// Loading accepts each transfer while in_stall_o is low. A transfer with final_item_i
// starts the sort: for n stored values, ceil(log2 n) merge passes, each merging one
// element per cycle from one memory bank into the other; then each result is read out
// through the StRead and StEmit states.
// Reset clears only control state; the banks need no clearing pass.
// in_stall_o is high from the final transfer until the last result sits in the output
// register; out_stall_i holds the output register and pauses the result readout.
module merge_sorter_top
  import msort_pkg::*;
#(
  parameter int unsigned MaxItems = MsMaxItems
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [MsDataWidth-1:0] sample_value_i,
  input  logic                          final_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [MsDataWidth-1:0] sorted_value_o,
  output logic                          run_end_o,
  output logic                          overflowed_o
);

  localparam int unsigned AW = $clog2(MaxItems);
  localparam int unsigned CW = $clog2(MaxItems + 1);
  localparam int unsigned SW = CW + 2;

  // Two banks, one write port and two read ports each, registered read data.
  logic signed [MsDataWidth-1:0] bank_a [MaxItems];
  logic signed [MsDataWidth-1:0] bank_b [MaxItems];
  logic signed [MsDataWidth-1:0] a_rd0_q, a_rd1_q, b_rd0_q, b_rd1_q;

  logic [MsStateWidth-1:0] state_q, state_d;
  logic [CW-1:0] fill_q, fill_d;
  logic          drop_q, drop_d;
  logic          sel_q, sel_d;     // 0: sorted data in bank A, merge A into B
  logic [CW:0]   width_q, width_d;
  logic [CW-1:0] lo_q, lo_d, mid_q, mid_d, hi_q, hi_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic [CW-1:0] idx_q, idx_d;

  logic          out_valid_q, out_valid_d;
  logic signed [MsDataWidth-1:0] out_value_q;
  logic          run_end_q, overflowed_q;
  logic          out_load;

  logic          in_xfer;
  logic          load_we;
  logic          merge_we;
  logic signed [MsDataWidth-1:0] lft, rgt, merge_data;
  logic          i_ok, j_ok, take_l;
  logic [SW-1:0] lo_nx, base, mid_c, hi_c, n_ext;
  logic [CW-1:0] mid_clip, hi_clip;
  logic [AW-1:0] rd0_addr, rd1_addr;
  logic          out_free;
  logic          emit_phase;

  assign in_stall_o = (state_q != StLoad);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign load_we    = in_xfer && (fill_q < CW'(MaxItems));
  assign merge_we   = (state_q == StMerge);
  assign emit_phase = (state_q == StRead) || (state_q == StEmit);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Merge step: take the left head when the right run is done or the left head is strictly smaller; ties go right.
  assign lft        = sel_q ? b_rd0_q : a_rd0_q;
  assign rgt        = sel_q ? b_rd1_q : a_rd1_q;
  assign i_ok       = i_q < mid_q;
  assign j_ok       = j_q < hi_q;
  assign take_l     = i_ok && (!j_ok || (lft < rgt));
  assign merge_data = take_l ? lft : rgt;

  // Run bounds for the next segment, clipped to the set size.
  assign n_ext    = SW'(fill_q);
  assign lo_nx    = SW'(lo_q) + SW'({width_q, 1'b0});
  assign base     = (state_q == StSetup) ? '0 : lo_nx;
  assign mid_c    = base + SW'(width_q);
  assign hi_c     = base + SW'({width_q, 1'b0});
  assign mid_clip = (mid_c > n_ext) ? fill_q : mid_c[CW-1:0];
  assign hi_clip  = (hi_c > n_ext) ? fill_q : hi_c[CW-1:0];

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    drop_d      = drop_q;
    sel_d       = sel_q;
    width_d     = width_q;
    lo_d        = lo_q;
    mid_d       = mid_q;
    hi_d        = hi_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    idx_d       = idx_q;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      StLoad: begin
        if (in_xfer) begin
          if (load_we) begin
            fill_d = fill_q + 1'b1;
          end else begin
            drop_d = 1'b1;
          end
          if (final_item_i) begin
            sel_d   = 1'b0;
            width_d = (CW + 1)'(1);
            state_d = StSetup;
          end
        end
      end
      StSetup: begin
        // Start a pass if runs remain: issue the reads of both run heads; else begin the readout.
        if (SW'(width_q) < n_ext) begin
          lo_d    = '0;
          mid_d   = mid_clip;
          hi_d    = hi_clip;
          i_d     = '0;
          j_d     = mid_clip;
          k_d     = '0;
          state_d = StMerge;
        end else begin
          idx_d   = '0;
          state_d = StRead;
        end
      end
      StMerge: begin
        i_d = i_q + CW'(take_l);
        j_d = j_q + CW'(!take_l);
        k_d = k_q + 1'b1;
        if (k_q + 1'b1 == hi_q) begin
          if (lo_nx < n_ext) begin
            lo_d  = lo_nx[CW-1:0];
            mid_d = mid_clip;
            hi_d  = hi_clip;
            i_d   = lo_nx[CW-1:0];
            j_d   = mid_clip;
            k_d   = lo_nx[CW-1:0];
          end else begin
            // Pass done: the written bank becomes the source.
            width_d = {width_q[CW-1:0], 1'b0};
            sel_d   = !sel_q;
            state_d = StSetup;
          end
        end
      end
      StRead: begin
        state_d = StEmit;
      end
      StEmit: begin
        // Hold the read address until the output register frees up.
        if (out_free) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          if (idx_q + 1'b1 == fill_q) begin
            fill_d  = '0;
            drop_d  = 1'b0;
            state_d = StLoad;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = StRead;
          end
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  assign rd0_addr = emit_phase ? idx_q[AW-1:0] : i_d[AW-1:0];
  assign rd1_addr = j_d[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (load_we) begin
      bank_a[fill_q[AW-1:0]] <= sample_value_i;
    end else if (merge_we && sel_q) begin
      bank_a[k_q[AW-1:0]] <= merge_data;
    end
    a_rd0_q <= bank_a[rd0_addr];
    a_rd1_q <= bank_a[rd1_addr];
  end

  always_ff @(posedge clk_i) begin
    if (merge_we && !sel_q) begin
      bank_b[k_q[AW-1:0]] <= merge_data;
    end
    b_rd0_q <= bank_b[rd0_addr];
    b_rd1_q <= bank_b[rd1_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      fill_q      <= '0;
      drop_q      <= 1'b0;
      sel_q       <= 1'b0;
      width_q     <= '0;
      lo_q        <= '0;
      mid_q       <= '0;
      hi_q        <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      drop_q      <= drop_d;
      sel_q       <= sel_d;
      width_q     <= width_d;
      lo_q        <= lo_d;
      mid_q       <= mid_d;
      hi_q        <= hi_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_value_q  <= sel_q ? b_rd0_q : a_rd0_q;
      run_end_q    <= (idx_q + 1'b1 == fill_q);
      overflowed_q <= drop_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sorted_value_o = out_value_q;
  assign run_end_o      = run_end_q;
  assign overflowed_o   = overflowed_q;

endmodule
